// ===== rtl/core/nd_grad_pkg.sv =====
// Shared widths, codes and types for the graduated ND mask pipeline.
`default_nettype none

package nd_grad_pkg;

  // coordinate format: signed Q2.(CoordWidth-2)
  localparam int CoordWidth = 16;
  localparam int FracBits   = CoordWidth - 2;
  localparam int ShR        = (FracBits >= 14) ? (FracBits - 14) : 0;
  localparam int ShL        = (FracBits < 14) ? (14 - FracBits) : 0;
  localparam int SumW       = CoordWidth + 1;
  localparam int XW         = SumW + ShL - ShR;

  localparam int StrW = 16;
  localparam int CfgW = (CoordWidth > StrW) ? CoordWidth : StrW;
  localparam int IdxW = 3;
  localparam int OutW = 16;

  // linear term: strength * coordinate
  localparam int LinW = StrW + 1 + XW;

  // radial term: isqrt((x*x + y*y) << 8)
  localparam int SqW          = 2 * XW;
  localparam int RadW         = SqW + 8;
  localparam int RootW        = RadW / 2;
  localparam int BitsPerStage = 3;
  localparam int SqrtStages   = (RootW + BitsPerStage - 1) / BitsPerStage;
  localparam int RootPW       = SqrtStages * BitsPerStage;
  localparam int PadW         = 2 * RootPW;
  localparam int RemW         = RootPW + 2;

  // flat term: floor(strength * 2^19 / 5) = strength*K + floor(3*strength/5)
  localparam int FlatKW     = 17;
  localparam int FlatMulW   = 20;
  localparam int RecipShift = 20;
  localparam int FlatRemI   = (1 << 19) % 5;
  localparam int RecipI     = ((1 << RecipShift) + 4) / 5;
  localparam logic [FlatKW-1:0]   FlatK   = FlatKW'((1 << 19) / 5);
  localparam logic [FlatMulW-1:0] FlatMul = FlatMulW'(FlatRemI * RecipI);
  localparam int FlatW = StrW + 18;

  // t in Q.30, r in Q.30
  localparam int TW = LinW + 5;
  localparam int RW = 31;
  localparam logic signed [TW-1:0] OneT    = TW'(1 << 30);
  localparam logic [RW-1:0]        OneR    = RW'(1 << 30);
  localparam logic [RW-1:0]        RndHalf = RW'(1 << 14);
  localparam logic [OutW-1:0]      OneQ15  = OutW'(1 << 15);

  // mode codes
  localparam logic [1:0] ModeHoriz  = 2'd0;
  localparam logic [1:0] ModeVert   = 2'd1;
  localparam logic [1:0] ModeRadial = 2'd2;
  localparam logic [1:0] ModeFlat   = 2'd3;

  // register indexes
  localparam logic [IdxW-1:0] RegMode     = 3'd0;
  localparam logic [IdxW-1:0] RegXOffset  = 3'd1;
  localparam logic [IdxW-1:0] RegYOffset  = 3'd2;
  localparam logic [IdxW-1:0] RegStrength = 3'd3;
  localparam logic [IdxW-1:0] RegInvert   = 3'd4;

  localparam logic [StrW-1:0] StrengthReset = StrW'(4096);

  // terms that ride alongside the square root
  typedef struct packed {
    logic signed [LinW-1:0] lin;
    logic [FlatW-1:0]       flat;
  } nd_side_t;

endpackage

`default_nettype wire

// ===== rtl/core/nd_gradient_mask.sv =====
// Graduated neutral-density mask weight: pipelined top level.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------
//  in      | sink      | in_valid_i / in_stall_o | x_coord_i, y_coord_i
//  out     | source    | out_valid_o/out_stall_i | mask_value_o
//  cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  One beat in and one beat out per clock while the output is not stalled; the pipe
//  has 3 front stages, 7 square-root stages of 3 root bits each and 3 back stages.
//  The square-root pipeline sets most of the depth; the multipliers sit in S2 and S11.
//  A stall on the output freezes every stage at once: nothing is dropped.
//  Reset clears the valid bits and loads the register defaults
//  (vignette mode, zero offsets, strength 1.0, no inversion).
`default_nettype none

module nd_gradient_mask (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // coordinate beats
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic signed [nd_grad_pkg::CoordWidth-1:0] x_coord_i,
  input  logic signed [nd_grad_pkg::CoordWidth-1:0] y_coord_i,
  // mask beats
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic [nd_grad_pkg::OutW-1:0]              mask_value_o,
  // register writes
  input  logic                                      cfg_we_i,
  input  logic [nd_grad_pkg::IdxW-1:0]              cfg_idx_i,
  input  logic [nd_grad_pkg::CfgW-1:0]              cfg_data_i
);
  import nd_grad_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [1:0]                   mode_q;
  logic signed [CoordWidth-1:0] x_off_q, y_off_q;
  logic [StrW-1:0]              strength_q;
  logic                         invert_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeRadial;
      x_off_q    <= '0;
      y_off_q    <= '0;
      strength_q <= StrengthReset;
      invert_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegMode:     mode_q     <= cfg_data_i[1:0];
        RegXOffset:  x_off_q    <= cfg_data_i[CoordWidth-1:0];
        RegYOffset:  y_off_q    <= cfg_data_i[CoordWidth-1:0];
        RegStrength: strength_q <= cfg_data_i[StrW-1:0];
        RegInvert:   invert_q   <= cfg_data_i[0];
        default:     ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipe moves unless the output beat is held.
  // ---------------------------------------------------------------------------
  logic pipe_en;
  logic v1_q, v2_q, v3_q, v11_q, v12_q, v13_q;
  logic v10;

  assign pipe_en    = !(v13_q && out_stall_i);
  assign in_stall_o = !pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q  <= in_valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      v11_q <= v10;
      v12_q <= v11_q;
      v13_q <= v12_q;
    end
  end

  // ---------------------------------------------------------------------------
  // S1: add offsets, rescale to 14 fraction bits (floor on the way down)
  // ---------------------------------------------------------------------------
  logic signed [SumW-1:0]     x_sum, y_sum;
  logic signed [SumW+ShL-1:0] x_ext, y_ext;
  logic signed [XW-1:0]       x1_d, y1_d, x1_q, y1_q;

  always_comb begin
    x_sum = SumW'(x_coord_i) + SumW'(x_off_q);
    y_sum = SumW'(y_coord_i) + SumW'(y_off_q);
    x_ext = (SumW+ShL)'(x_sum);
    y_ext = (SumW+ShL)'(y_sum);
    x1_d  = XW'((x_ext <<< ShL) >>> ShR);
    y1_d  = XW'((y_ext <<< ShL) >>> ShR);
  end

  // ---------------------------------------------------------------------------
  // S2: squares, linear product, flat-term partial products
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0]         lin_sel;
  logic signed [SqW-1:0]        xx2_d, yy2_d;
  logic [SqW-1:0]               xx2_q, yy2_q;
  logic signed [LinW-1:0]       lin2_d, lin2_q;
  logic [StrW+FlatKW-1:0]       fa2_d, fa2_q;
  logic [StrW+FlatMulW-1:0]     fb2_d, fb2_q;

  always_comb begin
    lin_sel = (mode_q == ModeVert) ? y1_q : x1_q;
    xx2_d   = x1_q * x1_q;
    yy2_d   = y1_q * y1_q;
    lin2_d  = $signed({1'b0, strength_q}) * lin_sel;
    fa2_d   = strength_q * FlatK;
    // 3*s/5 by reciprocal: exact for every 16-bit strength
    fb2_d   = strength_q * FlatMul;
  end

  // ---------------------------------------------------------------------------
  // S3: sum of squares, flat term completed
  // ---------------------------------------------------------------------------
  logic [SqW-1:0]   rad3_q;
  logic [FlatW-1:0] flat3_d;
  nd_side_t         side3_q;

  assign flat3_d = FlatW'(fa2_q) + FlatW'(fb2_q >> RecipShift);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x1_q         <= x1_d;
      y1_q         <= y1_d;
      xx2_q        <= $unsigned(xx2_d);
      yy2_q        <= $unsigned(yy2_d);
      lin2_q       <= lin2_d;
      fa2_q        <= fa2_d;
      fb2_q        <= fb2_d;
      rad3_q       <= xx2_q + yy2_q;
      side3_q.lin  <= lin2_q;
      side3_q.flat <= flat3_d;
    end
  end

  // ---------------------------------------------------------------------------
  // S4..S10: floor(sqrt(sum << 8)), root in Q.18
  // ---------------------------------------------------------------------------
  logic [RootW-1:0] root10;
  nd_side_t         side10;

  nd_grad_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v3_q),
    .rad_i   (PadW'({rad3_q, 8'b0})),
    .side_i  (side3_q),
    .valid_o (v10),
    .root_o  (root10),
    .side_o  (side10)
  );

  // ---------------------------------------------------------------------------
  // S11: radial term strength * root (Q.30)
  // S12: pick t by mode, r = 1 - t clamped to [0, 1]
  // S13: optional inversion, round half up to Q1.15
  // ---------------------------------------------------------------------------
  logic [StrW+RootW-1:0] trad11_q;
  nd_side_t              side11_q;
  logic signed [TW-1:0]  t12;
  logic [RW-1:0]         r12_d, r12_q;
  logic [RW-1:0]         r13, rnd13;
  logic [OutW-1:0]       mask13_d, mask13_q;

  always_comb begin
    case (mode_q)
      ModeHoriz, ModeVert: t12 = TW'(side11_q.lin) <<< 4;
      ModeRadial:          t12 = $signed(TW'(trad11_q));
      default:             t12 = $signed(TW'(side11_q.flat));
    endcase
    // t <= 0 saturates the weight at one, t >= 1 at zero
    if (t12[TW-1] || (t12 == OneT)) begin
      r12_d = t12[TW-1] ? OneR : '0;
    end else if (t12 > OneT) begin
      r12_d = '0;
    end else begin
      r12_d = RW'(OneT - t12);
    end
  end

  always_comb begin
    r13      = invert_q ? (OneR - r12_q) : r12_q;
    rnd13    = r13 + RndHalf;
    mask13_d = rnd13[RW-1 -: OutW];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      trad11_q <= strength_q * root10;
      side11_q <= side10;
      r12_q    <= r12_d;
      mask13_q <= mask13_d;
    end
  end

  assign out_valid_o  = v13_q;
  assign mask_value_o = mask13_q;

`ifndef SYNTHESIS
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mask_value_o <= OneQ15))
    else $error("mask weight above 1.0");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable({v1_q, v2_q, v3_q, v10, v11_q, v12_q, v13_q}))
    else $error("stage valid bits moved during a stall");

  a_zero_strength: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !invert_q && (strength_q == '0)) |-> (mask_value_o == OneQ15))
    else $error("zero strength must give full weight");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/nd_grad_sqrt.sv =====
// Pipelined restoring integer square root, a few root bits per stage.
`default_nettype none

module nd_grad_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [nd_grad_pkg::PadW-1:0]  rad_i,
  input  nd_grad_pkg::nd_side_t         side_i,
  output logic                          valid_o,
  output logic [nd_grad_pkg::RootW-1:0] root_o,
  output nd_grad_pkg::nd_side_t         side_o
);
  import nd_grad_pkg::*;

  logic              vld_q  [SqrtStages];
  logic [RootPW-1:0] root_q [SqrtStages];
  nd_side_t          side_q [SqrtStages];
  logic [PadW-1:0]   rad_q  [SqrtStages-1];
  logic [RemW-1:0]   rem_q  [SqrtStages-1];

  for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
    logic [PadW-1:0]   rad_in, rad_d;
    logic [RemW-1:0]   rem_in, rem_d, trial;
    logic [RootPW-1:0] root_in, root_d;
    logic              vld_in;
    nd_side_t          side_in;

    if (g == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign vld_in  = valid_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rad_in  = rad_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign vld_in  = vld_q[g-1];
      assign side_in = side_q[g-1];
    end

    // one root bit per step: bring down two radicand bits, try 4r+1
    always_comb begin
      rad_d  = rad_in;
      rem_d  = rem_in;
      root_d = root_in;
      trial  = '0;
      for (int k = 0; k < BitsPerStage; k++) begin
        rem_d = {rem_d[RemW-3:0], rad_d[PadW-1 -: 2]};
        rad_d = rad_d << 2;
        trial = {root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[RootPW-2:0], 1'b1};
        end else begin
          root_d = {root_d[RootPW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[g] <= root_d;
        side_q[g] <= side_in;
      end
    end

    if (g < SqrtStages - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[g] <= rad_d;
          rem_q[g] <= rem_d;
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1][RootW-1:0];
  assign side_o  = side_q[SqrtStages-1];

endmodule

`default_nettype wire

// ===== dv/nd_gradient_mask_tb.sv =====
// Self-checking testbench for the graduated ND mask weight pipeline.
module nd_gradient_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nd_grad_pkg::*;

  // Quiet-cycle limit: the slowest legal gap between beats is a sender pause,
  // the pipe latency and a receiver pause; the long output hold-off below is
  // the only thing that comes close to it.
  localparam int StallLimit   = 2000;
  localparam int DrainCycles  = 20;   // a little over the pipe depth
  localparam int HoldCycles   = 300;  // long output hold-off, fills the pipe
  localparam int RandomPhases = 15;
  localparam int PhaseBeats   = 110;
  localparam int PressBeats   = 80;

  localparam int     CoordOne = 1 << FracBits;       // 1.0 in the coordinate format
  localparam longint OneQ30   = longint'(1) << 30;   // 1.0 in the weight datapath

  typedef logic signed [CoordWidth-1:0] coord_t;

  localparam coord_t CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
  localparam coord_t CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

  // indexes past the last register: writes there must be dropped
  localparam logic [IdxW-1:0] RegFirstSpare = RegInvert + 1'b1;

  typedef struct {
    coord_t          x;
    coord_t          y;
    logic [OutW-1:0] mask;
  } mask_beat_t;

  // --------------------------------------------------------------------------
  // Block connections; every input is known from time zero
  // --------------------------------------------------------------------------
  logic              clk      = 1'b0;
  logic              rst_n    = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  coord_t            x_coord  = '0;
  coord_t            y_coord  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [OutW-1:0]   mask_value;
  logic              cfg_we   = 1'b0;
  logic [IdxW-1:0]   cfg_idx  = '0;
  logic [CfgW-1:0]   cfg_data = '0;

  nd_gradient_mask dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .x_coord_i    (x_coord),
    .y_coord_i    (y_coord),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .mask_value_o (mask_value),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow of the register file, as the block should hold it
  // --------------------------------------------------------------------------
  logic [1:0]      cur_mode     = ModeRadial;
  coord_t          cur_x_off    = '0;
  coord_t          cur_y_off    = '0;
  logic [StrW-1:0] cur_strength = StrengthReset;
  logic            cur_invert   = 1'b0;

  mask_beat_t pending_masks[$];   // weights still owed by the block, oldest first
  int         mismatches      = 0;
  bit         sender_pauses   = 1'b1;
  bit         receiver_pauses = 1'b1;
  int         hold_req        = 0;  // long hold-off asked of the mask sink
  int         stall_left      = 0;

  // floor of the square root, one result bit per pass
  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned probe;
    res   = 0;
    probe = longint'(1) << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n   -= res + probe;
        res  = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // Expected Q1.15 weight for one coordinate pair under the shadow registers.
  // Everything is carried in 64 bits, so nothing wraps before the clamp.
  function automatic logic [OutW-1:0] predict_mask(coord_t xc, coord_t yc);
    longint          xs;
    longint          ys;
    longint          s;
    longint          t;
    longint          r;
    longint unsigned energy;
    // offset sums are exact, then brought to 14 fraction bits
    xs = (longint'(xc) + longint'(cur_x_off)) >>> ShR;
    ys = (longint'(yc) + longint'(cur_y_off)) >>> ShR;
    xs = xs <<< ShL;
    ys = ys <<< ShL;
    s  = longint'(cur_strength);
    case (cur_mode)
      ModeHoriz: t = s * xs * 16;
      ModeVert:  t = s * ys * 16;
      ModeRadial: begin
        // root of (x^2 + y^2) << 8 is Q.18, times Q4.12 gives Q.30
        energy = longint'(xs * xs + ys * ys);
        t      = s * longint'(root_floor(energy << 8));
      end
      default:   t = (s <<< 19) / 5;  // 0.4 * strength, floored
    endcase
    r = OneQ30 - t;
    if (r < 0)      r = 0;
    if (r > OneQ30) r = OneQ30;
    if (cur_invert) r = OneQ30 - r;
    return OutW'((r + (longint'(1) << 14)) >>> 15);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Sender: one coordinate beat, with an optional pause in front of it.
  // Valid is left high afterwards so back-to-back beats never drop it.
  // --------------------------------------------------------------------------
  task automatic send_coord(input coord_t xc, input coord_t yc);
    int         gap;
    mask_beat_t beat;
    gap = sender_pauses ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    x_coord  = xc;
    y_coord  = yc;
    do @(posedge clk); while (in_stall);
    beat.x    = xc;
    beat.y    = yc;
    beat.mask = predict_mask(xc, yc);
    pending_masks.push_back(beat);
  endtask

  // Drop valid, let every owed weight arrive, then give the pipe time to empty.
  task automatic drain_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    @(posedge clk);
    // bits above a register's width are dropped, spare indexes do nothing
    case (idx)
      RegMode:     cur_mode     = data[1:0];
      RegXOffset:  cur_x_off    = data[CoordWidth-1:0];
      RegYOffset:  cur_y_off    = data[CoordWidth-1:0];
      RegStrength: cur_strength = data[StrW-1:0];
      RegInvert:   cur_invert   = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // All five registers; mode and invert go out with junk in the upper bits.
  task automatic load_config(input logic [1:0] m, input coord_t xo, input coord_t yo,
                             input logic [StrW-1:0] str, input logic inv);
    logic [CfgW-1:0] junk;
    junk      = CfgW'($urandom);
    junk[1:0] = m;
    write_reg(RegMode, junk);
    write_reg(RegXOffset, CfgW'(xo));
    write_reg(RegYOffset, CfgW'(yo));
    write_reg(RegStrength, CfgW'(str));
    junk    = CfgW'($urandom);
    junk[0] = inv;
    write_reg(RegInvert, junk);
  endtask

  // Half within +-1.0 so the weight lands inside [0,1]; the rest full range
  // or the very ends of the format.
  function automatic coord_t draw_coord();
    case ($urandom_range(0, 7))
      0:       return CoordMax;
      1:       return CoordMin;
      2, 3:    return coord_t'($urandom);
      default: return coord_t'(int'($urandom_range(0, 2 * CoordOne)) - CoordOne);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Mask sink: picks a pause after every beat it takes; a long hold-off request
  // overrides it. Counts its own cycles.
  // --------------------------------------------------------------------------
  always begin : mask_sink
    @(posedge clk);
    if (out_valid && !out_stall)
      stall_left = receiver_pauses ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end
    out_stall = (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // Every mask beat against the oldest owed weight
  always @(posedge clk) begin : mask_check
    mask_beat_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_masks.size() == 0) begin
        flag_mismatch($sformatf("mask beat %0d with nothing owed", mask_value));
      end else begin
        head = pending_masks.pop_front();
        if (mask_value !== head.mask)
          flag_mismatch($sformatf("x=%0d y=%0d: mask_value %0d, want %0d",
                                  head.x, head.y, mask_value, head.mask));
      end
    end
  end

  // Ends the run if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout: no beat moved for %0d cycles", StallLimit);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Register defaults straight out of reset: vignette, strength 1.0
  task automatic test_reset_defaults();
    send_coord('0, '0);                        // centre, full weight
    send_coord(coord_t'(CoordOne), '0);        // radius 1.0, weight exactly 0
    send_coord(coord_t'(CoordOne / 2), coord_t'(CoordOne / 2));
    send_coord(CoordMax, CoordMax);
    send_coord(CoordMin, CoordMin);            // widest radius the sums allow
  endtask

  // Each mode at the ends of its range: sums beyond the format, negative t,
  // huge strength, zero strength, inversion
  task automatic test_mode_extremes();
    drain_pipe();
    load_config(ModeHoriz, CoordMax, '0, StrengthReset, 1'b0);
    send_coord(CoordMin, '0);                  // sum -1: t < 0, weight pinned at 1.0
    send_coord(CoordMax, '0);                  // sum past +2.0, clamped to 0
    send_coord(CoordMin + coord_t'(CoordOne + 1), coord_t'($urandom));

    drain_pipe();
    load_config(ModeVert, '0, CoordMax, '1, 1'b1);
    send_coord(coord_t'($urandom), CoordMin);
    send_coord(coord_t'($urandom), CoordMin + coord_t'(1));
    send_coord(coord_t'($urandom), CoordMin + coord_t'(2));
    send_coord(coord_t'($urandom), CoordMax);

    drain_pipe();
    load_config(ModeRadial, CoordMin, CoordMin, StrW'(1), 1'b0);
    send_coord(CoordMin, CoordMin);            // both sums at -4.0
    send_coord(CoordMax, CoordMax);

    drain_pipe();
    load_config(ModeFlat, coord_t'($urandom), coord_t'($urandom), '0, 1'b0);
    send_coord(coord_t'($urandom), coord_t'($urandom));
    drain_pipe();
    load_config(ModeFlat, '0, '0, '1, 1'b0);   // 0.4 * 16.0: clamped to 0
    send_coord(coord_t'($urandom), coord_t'($urandom));
    drain_pipe();
    load_config(ModeFlat, '0, '0, StrengthReset, 1'b1);
    send_coord(coord_t'($urandom), coord_t'($urandom));
  endtask

  // Writes to the spare indexes must leave every register alone
  task automatic test_register_decode();
    drain_pipe();
    load_config(ModeHoriz, coord_t'(CoordOne / 4), '0, StrengthReset, 1'b0);
    for (int i = RegFirstSpare; i < (1 << IdxW); i++)
      write_reg(IdxW'(i), CfgW'($urandom));
    send_coord('0, '0);
    send_coord(coord_t'(CoordOne / 2), draw_coord());
    send_coord(draw_coord(), draw_coord());
  endtask

  // Random settings per phase, random pauses on either side; the first phases
  // walk the modes and pin the strength and offsets to their extremes
  task automatic test_random_settings();
    logic [1:0]      m;
    coord_t          xo;
    coord_t          yo;
    logic [StrW-1:0] str;
    for (int p = 0; p < RandomPhases; p++) begin
      drain_pipe();
      sender_pauses   = ($urandom_range(0, 3) != 0);
      receiver_pauses = ($urandom_range(0, 3) != 0);
      m  = (p < 4) ? 2'(p) : 2'($urandom);
      xo = ($urandom_range(0, 3) == 0) ? coord_t'($urandom)
                                       : coord_t'(int'($urandom_range(0, CoordOne)) - CoordOne / 2);
      yo = ($urandom_range(0, 3) == 0) ? coord_t'($urandom)
                                       : coord_t'(int'($urandom_range(0, CoordOne)) - CoordOne / 2);
      str = ($urandom_range(0, 3) == 0) ? StrW'($urandom)
                                        : StrW'($urandom_range(0, 2 * StrengthReset));
      if (p == 0) begin
        xo  = CoordMin;
        yo  = CoordMin;
        str = '1;
      end else if (p == 1) begin
        xo  = CoordMax;
        yo  = CoordMax;
        str = '0;
      end
      load_config(m, xo, yo, str, 1'($urandom));
      repeat (PhaseBeats) send_coord(draw_coord(), draw_coord());
    end
  endtask

  // Output held off for a long stretch while coordinates keep coming with no
  // gaps: the pipe fills and must push back on its input without losing beats
  task automatic test_output_backpressure();
    drain_pipe();
    sender_pauses   = 1'b0;
    receiver_pauses = 1'b1;
    load_config(ModeRadial, '0, '0, StrengthReset, 1'b0);
    @(posedge clk);
    hold_req = HoldCycles;
    repeat (PressBeats) send_coord(draw_coord(), draw_coord());
  endtask

  initial begin : run
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_mode_extremes();
    test_register_decode();
    test_random_settings();
    test_output_backpressure();

    drain_pipe();
    if (pending_masks.size() != 0)
      flag_mismatch($sformatf("%0d weights never arrived", pending_masks.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
